[design/wbsps_pkg.sv]
// Shared types and constants for the weighted bin sum pair scale unit.
// No dependencies; imported by the top level.
package wbsps_pkg;

   localparam int OP_W      = 2;
   localparam int INDEX_W   = 13;
   localparam int WEIGHT_W  = 32;
   localparam int COUNT_W   = 16;
   localparam int VALUE_W   = 64;
   localparam int BIN_W     = 48;
   localparam int POS_W     = 12;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 32;
   localparam int NTRK_W    = 13;
   localparam int ZS_W      = 32;

   typedef enum logic [OP_W-1:0] {
      OP_ACCUM = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_TRACKS = 1'b0,
      CSR_Z_SCALE    = 1'b1
   } csr_index_type;

   localparam logic [NTRK_W-1:0] NUM_TRACKS_RESET = 13'd1;
   localparam logic [ZS_W-1:0]   Z_SCALE_RESET    = 32'h0001_0000;

   localparam logic [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W-1){1'b1}}};
   localparam logic [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W-1){1'b0}}};

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

endpackage

[design/wbsps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the bin store.
module wbsps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/weighted_bin_sum_pair_scale_unit.sv]
// Accumulate: accept, RAM read, bin update; a dropped index skips the update.
// Readout: accept, RAM read, bin read and empty, six multiply/add steps, then the result
// after any wait for the output register; one shared 32x32 multiplier runs six products
// (g*(g-1), times Z, four partials against the bin magnitude). Clear: one bin written per
// cycle. Unused operation code: accepted and dropped. Reset: synchronous; registers take
// their reset values and a sweep zeroes the bin store before the first input transfer.
module weighted_bin_sum_pair_scale_unit #(
   parameter int BINS = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [wbsps_pkg::OP_W-1:0]             req_operation,
   input  logic [wbsps_pkg::INDEX_W-1:0]          req_bin_index,
   input  logic signed [wbsps_pkg::WEIGHT_W-1:0]  req_weight,
   input  logic [wbsps_pkg::COUNT_W-1:0]          req_track_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [wbsps_pkg::INDEX_W-1:0]          rsp_diag_index,
   output logic signed [wbsps_pkg::VALUE_W-1:0]   rsp_scaled_value,
   output logic                                   rsp_last_track,
   input  logic                                   csr_write,
   input  logic [wbsps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wbsps_pkg::CSR_W-1:0]            csr_data
);

   import wbsps_pkg::*;

   localparam int AW = $clog2(BINS);
   localparam logic [31:0] BINS_W = 32'(BINS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(BINS - 1);
   localparam int ACC_W = 112;
   localparam int MAG_W = BIN_W;

   // multiplier step sequence
   localparam logic [2:0] STEP_GG    = 3'd0;
   localparam logic [2:0] STEP_M     = 3'd1;
   localparam logic [2:0] STEP_LL    = 3'd2;
   localparam logic [2:0] STEP_LH    = 3'd3;
   localparam logic [2:0] STEP_HL    = 3'd4;
   localparam logic [2:0] STEP_HH    = 3'd5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_MUL,
      ST_ADD,
      ST_RESULT
   } state_type;

   state_type state_ff;

   // configuration
   logic [NTRK_W-1:0] num_tracks_ff;
   logic [ZS_W-1:0]   z_scale_ff;

   // latched item
   op_type               op_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic [WEIGHT_W-1:0]  weight_ff;
   logic [COUNT_W-1:0]   g_ff;

   logic [POS_W-1:0]     pos_ff;
   logic [AW-1:0]        clr_ff;
   logic [2:0]           step_ff;
   logic [63:0]          prod_ff;
   logic [31:0]          gg_ff;
   logic [63:0]          m_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic                 neg_ff;
   logic [MAG_W-1:0]     mag_ff;

   logic                 rsp_valid_ff;
   logic [INDEX_W-1:0]   rsp_diag_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_last_ff;

   // RAM port
   logic                 ram_we;
   logic [AW-1:0]        ram_wr_addr;
   logic [BIN_W-1:0]     ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [BIN_W-1:0]     ram_rd_data;

   logic                 idx_ok;
   logic                 pos_ok;
   logic [AW-1:0]        idx_addr;
   logic [AW-1:0]        pos_addr;
   logic [BIN_W:0]       bin_add;
   logic [BIN_W-1:0]     bin_sat;
   logic [BIN_W-1:0]     bin_rd;
   logic [MAG_W-1:0]     bin_neg;

   logic [31:0]          mul_a;
   logic [31:0]          mul_b;
   logic [63:0]          mul_prod;
   logic [ACC_W-1:0]     acc_addend;

   logic [ACC_W-17:0]    rounded;
   logic [VALUE_W-1:0]   rsp_value_in;
   logic [NTRK_W-1:0]    n_eff;
   logic [INDEX_W-1:0]   pos_next;
   logic                 last_in;
   logic                 accept;
   logic                 rsp_taken;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         num_tracks_ff <= NUM_TRACKS_RESET;
         z_scale_ff    <= Z_SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_TRACKS: num_tracks_ff <= csr_data[NTRK_W-1:0];
            CSR_Z_SCALE:    z_scale_ff    <= csr_data[ZS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- bin store
   assign idx_ok   = (idx_ff != '0) && ({19'd0, idx_ff} <= BINS_W);
   assign pos_ok   = ({20'd0, pos_ff} < BINS_W);
   assign idx_addr = AW'(idx_ff - 13'd1);
   assign pos_addr = AW'(pos_ff);

   assign bin_rd  = ram_rd_data;
   assign bin_add = {bin_rd[BIN_W-1], bin_rd}
                  + {{(BIN_W+1-WEIGHT_W){weight_ff[WEIGHT_W-1]}}, weight_ff};

   always_comb begin
      if (bin_add[BIN_W] != bin_add[BIN_W-1]) begin
         bin_sat = bin_add[BIN_W] ? BIN_MIN : BIN_MAX;
      end else begin
         bin_sat = bin_add[BIN_W-1:0];
      end
   end

   assign bin_neg = MAG_W'(0) - bin_rd;

   always_comb begin
      ram_we      = 1'b0;
      ram_wr_addr = pos_addr;
      ram_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         ram_we      = 1'b1;
         ram_wr_addr = clr_ff;
      end else if (state_ff == ST_UPDATE) begin
         if (op_ff == OP_ACCUM) begin
            ram_we      = 1'b1;
            ram_wr_addr = idx_addr;
            ram_wr_data = bin_sat;
         end else begin
            // readout empties the bin
            ram_we = pos_ok;
         end
      end
   end

   assign ram_rd_addr = (op_ff == OP_ACCUM) ? idx_addr : pos_addr;

   wbsps_ram #(
      .WIDTH (BIN_W),
      .DEPTH (BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- multiplier
   always_comb begin
      case (step_ff)
         STEP_GG: begin
            mul_a = {16'd0, g_ff};
            mul_b = {16'd0, g_ff - 16'd1};
         end
         STEP_M: begin
            mul_a = gg_ff;
            mul_b = z_scale_ff;
         end
         STEP_LL: begin
            mul_a = m_ff[31:0];
            mul_b = mag_ff[31:0];
         end
         STEP_LH: begin
            mul_a = m_ff[31:0];
            mul_b = {16'd0, mag_ff[MAG_W-1:32]};
         end
         STEP_HL: begin
            mul_a = m_ff[63:32];
            mul_b = mag_ff[31:0];
         end
         default: begin
            mul_a = m_ff[63:32];
            mul_b = {16'd0, mag_ff[MAG_W-1:32]};
         end
      endcase
   end

   // 32x32 unsigned
   assign mul_prod = mul_a * mul_b;

   always_comb begin
      case (step_ff)
         STEP_LL: acc_addend = ACC_W'(prod_ff);
         STEP_LH: acc_addend = ACC_W'(prod_ff) << 32;
         STEP_HL: acc_addend = ACC_W'(prod_ff) << 32;
         STEP_HH: acc_addend = ACC_W'(prod_ff) << 64;
         default: acc_addend = '0;
      endcase
   end

   // ---------------------------------------------------------------- result
   // accumulator starts at half an LSB, so the top bits are already rounded
   assign rounded = acc_ff[ACC_W-1:16];

   always_comb begin
      if (neg_ff) begin
         if (rounded[ACC_W-17:VALUE_W] != '0
             || (rounded[VALUE_W-1] && rounded[VALUE_W-2:0] != '0)) begin
            rsp_value_in = VALUE_MIN;
         end else begin
            rsp_value_in = VALUE_W'(0) - rounded[VALUE_W-1:0];
         end
      end else begin
         if (rounded[ACC_W-17:VALUE_W-1] != '0) begin
            rsp_value_in = VALUE_MAX;
         end else begin
            rsp_value_in = rounded[VALUE_W-1:0];
         end
      end
   end

   assign n_eff    = (num_tracks_ff == '0) ? NTRK_W'(1) : num_tracks_ff;
   assign pos_next = {1'b0, pos_ff} + 13'd1;
   assign last_in  = (pos_next >= n_eff) || (pos_ff == POS_MAX);

   assign accept    = req_valid && !req_stall;
   assign rsp_taken = rsp_valid_ff && !rsp_stall;

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         step_ff      <= STEP_GG;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_taken && state_ff != ST_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  op_ff     <= op_type'(req_operation);
                  idx_ff    <= req_bin_index;
                  weight_ff <= req_weight;
                  g_ff      <= req_track_count;
                  case (op_type'(req_operation))
                     OP_ACCUM: state_ff <= ST_FETCH;
                     OP_READ:  state_ff <= ST_FETCH;
                     OP_CLEAR: begin
                        clr_ff   <= '0;
                        state_ff <= ST_CLEAR;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_FETCH: begin
               // drop an accumulate to a bin outside the store
               if (op_ff == OP_ACCUM && !idx_ok) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (op_ff == OP_ACCUM) begin
                  state_ff <= ST_IDLE;
               end else begin
                  neg_ff   <= pos_ok && bin_rd[BIN_W-1];
                  mag_ff   <= !pos_ok ? '0 : (bin_rd[BIN_W-1] ? bin_neg : bin_rd);
                  acc_ff   <= ACC_W'(32'h0000_8000);
                  step_ff  <= STEP_GG;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= mul_prod;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               case (step_ff)
                  STEP_GG: gg_ff  <= prod_ff[31:0];
                  STEP_M:  m_ff   <= prod_ff;
                  default: acc_ff <= acc_ff + acc_addend;
               endcase
               step_ff <= step_ff + 3'd1;
               if (step_ff == STEP_HH) begin
                  state_ff <= ST_RESULT;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_RESULT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_diag_ff  <= pos_next;
                  rsp_value_ff <= rsp_value_in;
                  rsp_last_ff  <= last_in;
                  pos_ff       <= last_in ? '0 : pos_next[POS_W-1:0];
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_diag_index   = rsp_diag_ff;
   assign rsp_scaled_value = rsp_value_ff;
   assign rsp_last_track   = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result transfer raised outside the result state");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (pos_ff == '0))
      else $error("track counter not restarted after last track");

   a_pos_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> ({1'b0, pos_ff} == rsp_diag_ff))
      else $error("track counter out of step with pending result");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_ADD)
         |-> (!mag_ff[MAG_W-1] || mag_ff[MAG_W-2:0] == '0))
      else $error("bin magnitude exceeds signed bin range");

endmodule
